// ===== src/amgt_pkg.sv =====
// Shared types and constants for the adjacency matrix graph traversal core.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package amgt_pkg;

  localparam int OpW  = 3;
  localparam int VtxW = 3;
  localparam int LenW = 16;
  localparam int CfgW = 4;

  typedef enum logic [OpW-1:0] {
    OP_SET_EDGE = 3'd0,
    OP_CLR_EDGE = 3'd1,
    OP_RD_EDGE  = 3'd2,
    OP_BFS      = 3'd3,
    OP_DFS      = 3'd4
  } op_e;

  localparam logic StatusOk        = 1'b0;
  localparam logic StatusBadVertex = 1'b1;

endpackage

`default_nettype wire

// ===== src/amgt_in_if.sv =====
// Command channel: valid/ready handshake carrying one command item.
// Depends on amgt_pkg for field widths.
`default_nettype none

interface amgt_in_if;
  logic                             valid;
  logic                             ready;
  logic        [amgt_pkg::OpW-1:0]  opcode;
  logic        [amgt_pkg::VtxW-1:0] vertex_a;
  logic        [amgt_pkg::VtxW-1:0] vertex_b;
  logic signed [amgt_pkg::LenW-1:0] length;

  modport source (output valid, opcode, vertex_a, vertex_b, length, input ready);
  modport sink   (input valid, opcode, vertex_a, vertex_b, length, output ready);
endinterface

`default_nettype wire

// ===== src/amgt_out_if.sv =====
// Result channel: valid/ready handshake carrying one result item.
// Depends on amgt_pkg for field widths.
`default_nettype none

interface amgt_out_if;
  logic                             valid;
  logic                             ready;
  logic        [amgt_pkg::VtxW-1:0] visited_vertex;
  logic signed [amgt_pkg::LenW-1:0] edge_value;
  logic                             status;
  logic                             last;

  modport source (output valid, visited_vertex, edge_value, status, last, input ready);
  modport sink   (input valid, visited_vertex, edge_value, status, last, output ready);
endinterface

`default_nettype wire

// ===== src/amgt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module amgt_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/adjacency_matrix_graph_traversal_core.sv =====
// Top level of the graph traversal core: edge matrix, walk sequencer, result register.
// Depends on amgt_pkg, amgt_in_if, amgt_out_if and amgt_ram.
`default_nettype none

// Holds a symmetric matrix of signed 16-bit edge lengths over MaxVertices vertices, of
// which vertex_count are in use; a positive length is an edge. One command item is taken
// at a time. Set and clear write the cell and its mirror in turn, read reads the cell, and
// each then loads the result register. A walk pops pending vertices from a queue
// (breadth-first) or stack (depth-first), skipping depth-first duplicates, and scans one
// matrix row per visited vertex at one cell per cycle through the single edge RAM read
// port; a walk can wait on the result side. After reset the core zeroes the edge matrix,
// one cell a cycle, before taking the first item; vertex_count may be written meanwhile.
module adjacency_matrix_graph_traversal_core #(
  parameter int MaxVertices = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [amgt_pkg::CfgW-1:0] cfg_wdata_i,
  amgt_in_if.sink                        in_i,
  amgt_out_if.source                     out_o
);

  localparam int Depth = MaxVertices * MaxVertices;
  localparam int IW    = $clog2(MaxVertices);
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(Depth + 1);
  localparam int VCW   = $clog2(MaxVertices + 1);
  localparam int LW    = amgt_pkg::LenW;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_EDGE2  = 9'b000000100,
    ST_RDEDGE = 9'b000001000,
    ST_RESP   = 9'b000010000,
    ST_POP    = 9'b000100000,
    ST_POPD   = 9'b001000000,
    ST_VISIT  = 9'b010000000,
    ST_SCAN   = 9'b100000000
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
    cell_addr = AW'(32'(r) * MaxVertices + 32'(c));
  endfunction

  state_e st_q, st_d;
  logic   flush_q, flush_d;

  logic [VCW-1:0]        vc_q, vc_d;
  amgt_pkg::op_e         op_q, op_d;
  logic [IW-1:0]         a_q, a_d, b_q, b_d;
  logic [LW-1:0]         len_q, len_d;
  logic                  err_q, err_d;
  logic [LW-1:0]         edge_q, edge_d;
  logic [IW-1:0]         cur_q, cur_d;
  logic [MaxVertices-1:0] marks_q, marks_d;
  logic [PW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [IW-1:0]         scan_idx_q, scan_idx_d;
  logic [VCW-1:0]        scan_left_q, scan_left_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IW-1:0]         chk_idx_q, chk_idx_d;
  logic                  hold_vld_q, hold_vld_d;
  logic [IW-1:0]         hold_vtx_q, hold_vtx_d;
  logic [AW-1:0]         clr_q, clr_d;

  logic                      out_vld_q, out_vld_d;
  logic [amgt_pkg::VtxW-1:0] out_vtx_q, out_vtx_d;
  logic [LW-1:0]             out_edge_q, out_edge_d;
  logic                      out_status_q, out_status_d;
  logic                      out_last_q, out_last_d;

  logic          e_we, e_re, p_we, p_re;
  logic [AW-1:0] e_waddr, e_raddr, p_waddr, p_raddr;
  logic [LW-1:0] e_wdata, e_rdata;
  logic [IW-1:0] p_wdata, p_rdata;

  logic          acc, out_free, bad_a, bad_b, is_dfs, edge_pos;
  amgt_pkg::op_e in_op;

  amgt_ram #(.Width(LW), .Depth(Depth)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .re_i   (e_re),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  amgt_ram #(.Width(IW), .Depth(Depth)) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  assign in_i.ready = (st_q == ST_IDLE) && !flush_q;
  assign acc        = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign in_op      = amgt_pkg::op_e'(in_i.opcode);
  assign bad_a      = 32'(in_i.vertex_a) >= 32'(vc_q);
  assign bad_b      = 32'(in_i.vertex_b) >= 32'(vc_q);
  assign is_dfs     = (op_q == amgt_pkg::OP_DFS);
  assign edge_pos   = !e_rdata[LW-1] && (e_rdata != '0);

  always_comb begin
    st_d         = st_q;
    flush_d      = flush_q;
    vc_d         = vc_q;
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    len_d        = len_q;
    err_d        = err_q;
    edge_d       = edge_q;
    cur_d        = cur_q;
    marks_d      = marks_q;
    head_d       = head_q;
    tail_d       = tail_q;
    scan_idx_d   = scan_idx_q;
    scan_left_d  = scan_left_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    hold_vld_d   = hold_vld_q;
    hold_vtx_d   = hold_vtx_q;
    clr_d        = clr_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_vtx_d    = out_vtx_q;
    out_edge_d   = out_edge_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    e_we         = 1'b0;
    e_waddr      = '0;
    e_wdata      = '0;
    e_re         = 1'b0;
    e_raddr      = '0;
    p_we         = 1'b0;
    p_waddr      = '0;
    p_wdata      = '0;
    p_re         = 1'b0;
    p_raddr      = '0;

    if (cfg_we_i) begin
      if (32'(cfg_wdata_i) > MaxVertices) begin
        vc_d = VCW'(MaxVertices);
      end else begin
        vc_d = VCW'(cfg_wdata_i);
      end
    end

    case (st_q)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (flush_q) begin
          // final walk result, held until the output register is free
          if (out_free) begin
            out_vld_d    = 1'b1;
            out_vtx_d    = amgt_pkg::VtxW'(hold_vtx_q);
            out_edge_d   = '0;
            out_status_d = amgt_pkg::StatusOk;
            out_last_d   = 1'b1;
            flush_d      = 1'b0;
          end
        end else if (acc) begin
          op_d   = in_op;
          a_d    = IW'(in_i.vertex_a);
          b_d    = IW'(in_i.vertex_b);
          edge_d = '0;
          case (in_op)
            amgt_pkg::OP_SET_EDGE, amgt_pkg::OP_CLR_EDGE: begin
              err_d = bad_a || bad_b;
              len_d = (in_op == amgt_pkg::OP_SET_EDGE) ? in_i.length : '0;
              if (bad_a || bad_b) begin
                st_d = ST_RESP;
              end else begin
                e_we    = 1'b1;
                e_waddr = cell_addr(IW'(in_i.vertex_a), IW'(in_i.vertex_b));
                e_wdata = len_d;
                st_d    = ST_EDGE2;
              end
            end
            amgt_pkg::OP_RD_EDGE: begin
              err_d = bad_a || bad_b;
              if (bad_a || bad_b) begin
                st_d = ST_RESP;
              end else begin
                e_re    = 1'b1;
                e_raddr = cell_addr(IW'(in_i.vertex_a), IW'(in_i.vertex_b));
                st_d    = ST_RDEDGE;
              end
            end
            amgt_pkg::OP_BFS, amgt_pkg::OP_DFS: begin
              err_d = bad_a;
              if (bad_a) begin
                st_d = ST_RESP;
              end else begin
                p_we       = 1'b1;
                p_waddr    = '0;
                p_wdata    = IW'(in_i.vertex_a);
                head_d     = '0;
                tail_d     = PW'(1);
                hold_vld_d = 1'b0;
                marks_d    = '0;
                if (in_op == amgt_pkg::OP_BFS) begin
                  marks_d[IW'(in_i.vertex_a)] = 1'b1;
                end
                st_d = ST_POP;
              end
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EDGE2: begin
        e_we    = 1'b1;
        e_waddr = cell_addr(b_q, a_q);
        e_wdata = len_q;
        st_d    = ST_RESP;
      end
      ST_RDEDGE: begin
        edge_d = e_rdata;
        st_d   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_vtx_d    = '0;
          out_edge_d   = edge_q;
          out_status_d = err_q ? amgt_pkg::StatusBadVertex : amgt_pkg::StatusOk;
          out_last_d   = 1'b1;
          st_d         = ST_IDLE;
        end
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          flush_d = 1'b1;
          st_d    = ST_IDLE;
        end else begin
          p_re = 1'b1;
          if (is_dfs) begin
            p_raddr = AW'(tail_q - PW'(1));
            tail_d  = tail_q - PW'(1);
          end else begin
            p_raddr = AW'(head_q);
            head_d  = head_q + PW'(1);
          end
          st_d = ST_POPD;
        end
      end
      ST_POPD: begin
        cur_d = p_rdata;
        st_d  = ST_VISIT;
      end
      ST_VISIT: begin
        if (is_dfs && marks_q[cur_q]) begin
          st_d = ST_POP;
        end else if (!hold_vld_q || out_free) begin
          if (hold_vld_q) begin
            out_vld_d    = 1'b1;
            out_vtx_d    = amgt_pkg::VtxW'(hold_vtx_q);
            out_edge_d   = '0;
            out_status_d = amgt_pkg::StatusOk;
            out_last_d   = 1'b0;
          end
          hold_vld_d = 1'b1;
          hold_vtx_d = cur_q;
          if (is_dfs) begin
            marks_d[cur_q] = 1'b1;
          end
          scan_left_d = vc_q;
          scan_idx_d  = is_dfs ? IW'(vc_q - VCW'(1)) : '0;
          chk_vld_d   = 1'b0;
          st_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_vld_q && edge_pos && !marks_q[chk_idx_q] && (tail_q < PW'(Depth))) begin
          p_we    = 1'b1;
          p_waddr = AW'(tail_q);
          p_wdata = chk_idx_q;
          tail_d  = tail_q + PW'(1);
          if (!is_dfs) begin
            marks_d[chk_idx_q] = 1'b1;
          end
        end
        if (scan_left_q != '0) begin
          e_re        = 1'b1;
          e_raddr     = cell_addr(cur_q, scan_idx_q);
          chk_vld_d   = 1'b1;
          chk_idx_d   = scan_idx_q;
          scan_idx_d  = is_dfs ? scan_idx_q - IW'(1) : scan_idx_q + IW'(1);
          scan_left_d = scan_left_q - VCW'(1);
        end else begin
          chk_vld_d = 1'b0;
          st_d      = ST_POP;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_CLEAR;
      flush_q    <= 1'b0;
      vc_q       <= '0;
      clr_q      <= '0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
      chk_vld_q  <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      marks_q    <= '0;
    end else begin
      st_q       <= st_d;
      flush_q    <= flush_d;
      vc_q       <= vc_d;
      clr_q      <= clr_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
      chk_vld_q  <= chk_vld_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      marks_q    <= marks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    a_q          <= a_d;
    b_q          <= b_d;
    len_q        <= len_d;
    err_q        <= err_d;
    edge_q       <= edge_d;
    cur_q        <= cur_d;
    scan_idx_q   <= scan_idx_d;
    scan_left_q  <= scan_left_d;
    chk_idx_q    <= chk_idx_d;
    hold_vtx_q   <= hold_vtx_d;
    out_vtx_q    <= out_vtx_d;
    out_edge_q   <= out_edge_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.visited_vertex = out_vtx_q;
  assign out_o.edge_value     = out_edge_q;
  assign out_o.status         = out_status_q;
  assign out_o.last           = out_last_q;

  a_flush_has_vertex : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> hold_vld_q)
    else $error("walk finishing without a visited vertex");

  a_queue_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("pending read pointer passed write pointer");

  a_walk_bad_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_op == amgt_pkg::OP_BFS || in_op == amgt_pkg::OP_DFS) && bad_a)
      |=> (st_q == ST_RESP))
    else $error("walk from unused vertex not reported as error");

  a_scan_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> (hold_vld_q && (op_q == amgt_pkg::OP_BFS || is_dfs)))
    else $error("row scan outside a walk");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for adjacency_matrix_graph_traversal_core: edge commands and walks,
// each result checked against a graph predictor held in the bench.
// Depends on amgt_pkg, amgt_in_if, amgt_out_if and the core itself.
module tb_top;

  localparam int NumVertices  = 8;
  localparam int IdleMax      = 16;
  localparam int SettleCycles = 200;
  localparam int CycleLimit   = 500_000;
  localparam int PhaseItems   = 28;

  localparam logic [amgt_pkg::OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [amgt_pkg::OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [amgt_pkg::OpW-1:0] OpSpare7 = 3'd7;

  typedef struct packed {
    logic [amgt_pkg::OpW-1:0]         opcode;
    logic [amgt_pkg::VtxW-1:0]        vertex_a;
    logic [amgt_pkg::VtxW-1:0]        vertex_b;
    logic signed [amgt_pkg::LenW-1:0] length;
    bit                               drain_first;
  } command_t;

  typedef struct packed {
    logic [amgt_pkg::VtxW-1:0]        visited_vertex;
    logic signed [amgt_pkg::LenW-1:0] edge_value;
    logic                             status;
    logic                             last;
  } result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [amgt_pkg::CfgW-1:0] cfg_wdata_i;

  amgt_in_if  cmd_if ();
  amgt_out_if res_if ();

  adjacency_matrix_graph_traversal_core #(
    .MaxVertices(NumVertices)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  // predicted graph state
  logic signed [amgt_pkg::LenW-1:0] edge_len [NumVertices][NumVertices];
  int                               active_vertices;

  command_t    pending_cmds[$];
  result_t     expected_results[$];
  command_t    cur_cmd;
  result_t     oldest;
  bit          have_cmd;
  bit          send_idle;
  bit          recv_idle;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned fail_count;
  int unsigned cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_link(int r, int c);
    return edge_len[r][c] > 0;
  endfunction

  // Works out the results of one accepted item and updates the graph.
  function automatic void predict_results(command_t c);
    result_t                   r;
    logic [amgt_pkg::VtxW-1:0] walk_q[$];
    logic [amgt_pkg::VtxW-1:0] order[$];
    logic [NumVertices-1:0]    seen;
    logic [amgt_pkg::VtxW-1:0] v;
    if (c.opcode > amgt_pkg::OP_DFS) return;
    r = '0;
    r.status = amgt_pkg::StatusOk;
    r.last = 1'b1;
    if (c.vertex_a >= active_vertices ||
        (c.opcode <= amgt_pkg::OP_RD_EDGE && c.vertex_b >= active_vertices)) begin
      r.status = amgt_pkg::StatusBadVertex;
      expected_results = {expected_results, r};
      return;
    end
    seen = '0;
    case (c.opcode)
      amgt_pkg::OP_SET_EDGE: begin
        edge_len[c.vertex_a][c.vertex_b] = c.length;
        edge_len[c.vertex_b][c.vertex_a] = c.length;
        expected_results = {expected_results, r};
      end
      amgt_pkg::OP_CLR_EDGE: begin
        edge_len[c.vertex_a][c.vertex_b] = '0;
        edge_len[c.vertex_b][c.vertex_a] = '0;
        expected_results = {expected_results, r};
      end
      amgt_pkg::OP_RD_EDGE: begin
        r.edge_value = edge_len[c.vertex_a][c.vertex_b];
        expected_results = {expected_results, r};
      end
      amgt_pkg::OP_BFS: begin
        seen[c.vertex_a] = 1'b1;
        walk_q = {walk_q, c.vertex_a};
        while (walk_q.size() > 0) begin
          v = walk_q.pop_front();
          order = {order, v};
          for (int i = 0; i < active_vertices; i++) begin
            if (is_link(v, i) && !seen[i]) begin
              seen[i] = 1'b1;
              walk_q = {walk_q, amgt_pkg::VtxW'(i)};
            end
          end
        end
      end
      default: begin
        // depth-first: stack, duplicates skipped on pop
        walk_q = {walk_q, c.vertex_a};
        while (walk_q.size() > 0) begin
          v = walk_q.pop_back();
          if (!seen[v]) begin
            seen[v] = 1'b1;
            order = {order, v};
            for (int i = active_vertices - 1; i >= 0; i--) begin
              if (is_link(v, i) && !seen[i]) walk_q = {walk_q, amgt_pkg::VtxW'(i)};
            end
          end
        end
      end
    endcase
    foreach (order[k]) begin
      r.visited_vertex = order[k];
      r.last = (k == order.size() - 1);
      expected_results = {expected_results, r};
    end
  endfunction

  function automatic logic [amgt_pkg::VtxW-1:0] pick_vertex();
    if (active_vertices > 0 && $urandom_range(99, 0) < 85)
      return amgt_pkg::VtxW'($urandom_range(active_vertices - 1, 0));
    return amgt_pkg::VtxW'($urandom_range(NumVertices - 1, 0));
  endfunction

  function automatic void queue_cmd(logic [amgt_pkg::OpW-1:0] op,
                                    logic [amgt_pkg::VtxW-1:0] a,
                                    logic [amgt_pkg::VtxW-1:0] b,
                                    logic signed [amgt_pkg::LenW-1:0] len);
    command_t c;
    c.opcode = op;
    c.vertex_a = a;
    c.vertex_b = b;
    c.length = len;
    c.drain_first = 1'b0;
    pending_cmds = {pending_cmds, c};
  endfunction

  task automatic set_vertex_count(input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= amgt_pkg::CfgW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    active_vertices = value > NumVertices ? NumVertices : value;
  endtask

  // Waits for every item to be taken and every result to arrive, then lets
  // the core finish any item that gives no result.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_cmds.size() > 0 || have_cmd || expected_results.size() > 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.opcode   <= '0;
      cmd_if.vertex_a <= '0;
      cmd_if.vertex_b <= '0;
      cmd_if.length   <= '0;
      have_cmd = 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_results(cur_cmd);
        have_cmd = 1'b0;
      end
      if (!have_cmd && pending_cmds.size() > 0 &&
          (!pending_cmds[0].drain_first || expected_results.size() == 0)) begin
        cur_cmd = pending_cmds.pop_front();
        have_cmd = 1'b1;
        send_gap = send_idle ? $urandom_range(IdleMax, 0) : 0;
      end
      if (have_cmd && send_gap == 0) begin
        cmd_if.valid <= 1'b1;
      end else begin
        cmd_if.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
      cmd_if.opcode   <= cur_cmd.opcode;
      cmd_if.vertex_a <= cur_cmd.vertex_a;
      cmd_if.vertex_b <= cur_cmd.vertex_b;
      cmd_if.length   <= cur_cmd.length;
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: vertex %0d value %0d status %0b last %0b",
                 res_if.visited_vertex, res_if.edge_value, res_if.status, res_if.last);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (res_if.visited_vertex !== oldest.visited_vertex) begin
            $error("visited_vertex: expected %0d, got %0d",
                   oldest.visited_vertex, res_if.visited_vertex);
            fail_count++;
          end
          if (res_if.edge_value !== oldest.edge_value) begin
            $error("edge_value: expected %0d, got %0d", oldest.edge_value, res_if.edge_value);
            fail_count++;
          end
          if (res_if.status !== oldest.status) begin
            $error("status: expected %0b, got %0b", oldest.status, res_if.status);
            fail_count++;
          end
          if (res_if.last !== oldest.last) begin
            $error("last: expected %0b, got %0b", oldest.last, res_if.last);
            fail_count++;
          end
        end
        recv_stall = recv_idle ? $urandom_range(IdleMax, 0) : 0;
      end
      if (recv_stall > 0) begin
        res_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("** adjacency_matrix_graph_traversal_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned phase_counts[7];
    int          made;
    int unsigned pick;
    command_t    c;
    phase_counts = '{9, 3, 1, 5, 2, 8, 6};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    cmd_if.valid    = 1'b0;
    cmd_if.opcode   = '0;
    cmd_if.vertex_a = '0;
    cmd_if.vertex_b = '0;
    cmd_if.length   = '0;
    res_if.ready    = 1'b0;
    cur_cmd         = '0;
    send_idle       = 1'b0;
    recv_idle       = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    active_vertices = 0;
    foreach (edge_len[r, k]) edge_len[r][k] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // no vertices in use: everything is an error, spare opcodes are dropped
    set_vertex_count(0);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd0, 3'd0, 16'sd1);
    queue_cmd(amgt_pkg::OP_CLR_EDGE, 3'd0, 3'd0, '0);
    queue_cmd(amgt_pkg::OP_RD_EDGE, 3'd0, 3'd0, '0);
    queue_cmd(OpSpare7, 3'd7, 3'd7, -16'sd1);
    queue_cmd(amgt_pkg::OP_BFS, 3'd0, 3'd0, '0);
    queue_cmd(amgt_pkg::OP_DFS, 3'd0, 3'd0, '0);
    settle();

    // above-range count saturates; length extremes, self loop, negative length
    set_vertex_count(15);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd0, 3'd7, 16'sd32767);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd7, 3'd3, 16'sh8000);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd3, 3'd3, 16'sd5);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd0, 3'd1, 16'sd1);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd1, 3'd2, 16'sd100);
    queue_cmd(amgt_pkg::OP_SET_EDGE, 3'd2, 3'd4, -16'sd1);
    queue_cmd(amgt_pkg::OP_RD_EDGE, 3'd7, 3'd0, '0);
    queue_cmd(amgt_pkg::OP_RD_EDGE, 3'd3, 3'd7, '0);
    queue_cmd(amgt_pkg::OP_BFS, 3'd0, 3'd5, '0);
    queue_cmd(amgt_pkg::OP_DFS, 3'd0, 3'd2, '0);
    queue_cmd(amgt_pkg::OP_BFS, 3'd3, 3'd0, '0);
    queue_cmd(amgt_pkg::OP_CLR_EDGE, 3'd7, 3'd0, 16'sd7);
    queue_cmd(amgt_pkg::OP_RD_EDGE, 3'd0, 3'd7, '0);
    queue_cmd(OpSpare5, 3'd1, 3'd2, 16'sd3);
    queue_cmd(OpSpare6, 3'd4, 3'd5, 16'sd9);
    queue_cmd(amgt_pkg::OP_DFS, 3'd7, 3'd7, '0);
    settle();

    for (int p = 0; p < 7; p++) begin
      set_vertex_count(phase_counts[p]);
      send_idle = (p % 4 == 1) || (p % 4 == 3);
      recv_idle = (p % 4 >= 2);
      made = 0;
      while (made < PhaseItems) begin
        pick = $urandom_range(99, 0);
        c.vertex_a = pick_vertex();
        c.vertex_b = pick_vertex();
        c.length = ($urandom_range(9, 0) < 7) ? amgt_pkg::LenW'($urandom_range(32767, 1))
                                              : amgt_pkg::LenW'($urandom_range(65535, 0));
        c.drain_first = (made == PhaseItems / 3);
        if (pick < 40)      c.opcode = amgt_pkg::OP_SET_EDGE;
        else if (pick < 50) c.opcode = amgt_pkg::OP_CLR_EDGE;
        else if (pick < 62) c.opcode = amgt_pkg::OP_RD_EDGE;
        else if (pick < 78) c.opcode = amgt_pkg::OP_BFS;
        else if (pick < 94) c.opcode = amgt_pkg::OP_DFS;
        else                c.opcode = amgt_pkg::OpW'($urandom_range(OpSpare7, OpSpare5));
        pending_cmds = {pending_cmds, c};
        if (c.opcode <= amgt_pkg::OP_DFS) made++;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("** adjacency_matrix_graph_traversal_core: PASSED **");
    end else begin
      $display("** adjacency_matrix_graph_traversal_core: FAILED **");
    end
    $finish;
  end

endmodule
